// ===== rtl/tdq_pkg.sv =====
package tdq_pkg;

  // Kind of a queue entry; also used for the feedback_added field,
  // where KIND_DATA means no feedback entry was inserted.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_SLOW = 2'd1,
    KIND_FAST = 2'd2
  } kind_t;

  typedef enum logic {
    ACT_ARRIVE = 1'b0,
    ACT_END    = 1'b1
  } act_t;

  localparam int HANDLE_W = 32;
  localparam int DUR_W    = 16;
  localparam int BS_W     = 8;
  localparam int OCC_W    = 9;
  localparam int DROPS_W  = 32;

  localparam logic [BS_W-1:0] BS_RESET = 8'd200;
  localparam logic [BS_W-1:0] HI_RESET = 8'd180;  // floor(9*200/10)
  localparam logic [BS_W-1:0] LO_RESET = 8'd100;  // floor(200/2)

  // x/10 == (x*52429) >> 19 for every x below 2296
  localparam logic [15:0] DIV10_MUL = 16'd52429;

  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic [DUR_W-1:0]     duration;
  } entry_t;

  typedef struct packed {
    logic [BS_W-1:0] bs;
    logic [BS_W-1:0] hi;
    logic [BS_W-1:0] lo;
  } thr_t;

  typedef struct packed {
    logic                sent;
    kind_t               sent_kind;
    logic [HANDLE_W-1:0] sent_handle;
    logic [DUR_W-1:0]    sent_duration;
    logic                dropped;
    kind_t               feedback_added;
    logic [DROPS_W-1:0]  drops_so_far;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

endpackage

// ===== rtl/tdq_ram.sv =====
module tdq_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/tdq_thresh.sv =====
module tdq_thresh (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  output tdq_pkg::thr_t          thr
);

  import tdq_pkg::*;

  logic [BS_W-1:0] bs_r, hi_r, lo_r;
  logic [11:0]     nine;
  logic [27:0]     prod;

  // floor(9*bs/10) through a reciprocal multiply
  assign nine = 12'(cfg_wdata) * 12'd9;
  assign prod = 28'(nine) * 28'(DIV10_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= BS_RESET;
      hi_r <= HI_RESET;
      lo_r <= LO_RESET;
    end else if (cfg_we) begin
      bs_r <= cfg_wdata;
      hi_r <= prod[26:19];
      lo_r <= cfg_wdata >> 1;
    end
  end

  assign thr = '{bs: bs_r, hi: hi_r, lo: lo_r};

endmodule

// ===== rtl/tdq_core.sv =====
module tdq_core #(
  parameter int CAPACITY = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic                          act,
  input  logic [tdq_pkg::HANDLE_W-1:0]  handle,
  input  logic [tdq_pkg::DUR_W-1:0]     duration,
  input  tdq_pkg::thr_t                 thr,
  output tdq_pkg::res_t                 res,
  output logic                          pend
);

  import tdq_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = AW + 1;
  localparam int CMPW = (CW > BS_W) ? CW : BS_W;
  localparam logic [AW-1:0] LAST  = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ROOM2 = CW'(CAPACITY - 2);
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [DROPS_W-1:0] drops_r, drops_nxt;
  logic               pend_r, pend_nxt;
  entry_t             pend_d_r, pend_d_nxt;
  logic               ovr_v_r, ovr_v_nxt;
  entry_t             ovr_d_r, ovr_d_nxt;

  logic               wr_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  entry_t             wr_data;
  logic [$bits(entry_t)-1:0] rd_data;

  entry_t        head_ent, data_e, fb_e, popped;
  logic [SW-1:0] sum;
  logic [AW-1:0] tail, head_inc, head_dec;
  logic          full, slow, fast, fb_room, fb_ok, sent, dropped;
  kind_t         fb_kind, fb;

  tdq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Head entry: store read, unless written in the cycle the read was issued or held as a pending feedback write
  assign head_ent = ovr_v_r ? ovr_d_r : entry_t'(rd_data);

  assign sum      = SW'(head_r) + SW'(cnt_r);
  assign tail     = (sum >= CAP_S) ? AW'(sum - CAP_S) : AW'(sum);
  assign head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? LAST : head_r - AW'(1);

  assign full    = (CMPW'(cnt_r) >= CMPW'(thr.bs)) || (cnt_r >= CAP_C);
  assign slow    = CMPW'(cnt_r) >= CMPW'(thr.hi);
  assign fast    = CMPW'(cnt_r) >  CMPW'(thr.lo);
  assign fb_room = cnt_r <= ROOM2;
  assign fb_kind = slow ? KIND_SLOW : (fast ? KIND_FAST : KIND_DATA);
  assign fb_ok   = (fb_kind != KIND_DATA) && fb_room;

  assign data_e = '{kind: KIND_DATA, handle: handle, duration: duration};
  assign fb_e   = '{kind: fb_kind, handle: '0, duration: '0};

  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    drops_nxt  = drops_r;
    pend_nxt   = 1'b0;
    pend_d_nxt = pend_d_r;
    wr_en      = 1'b0;
    wr_addr    = tail;
    wr_data    = data_e;
    sent       = 1'b0;
    dropped    = 1'b0;
    fb         = KIND_DATA;
    popped     = '0;

    if (pend_r) begin
      // second store write of a busy arrival: the feedback entry at the head
      wr_en   = 1'b1;
      wr_addr = head_r;
      wr_data = pend_d_r;
    end else if (go) begin
      unique case (act_t'(act))
        ACT_ARRIVE: begin
          if (full) begin
            dropped   = 1'b1;
            drops_nxt = (drops_r == '1) ? drops_r : drops_r + DROPS_W'(1);
          end else begin
            fb    = fb_ok ? fb_kind : KIND_DATA;
            wr_en = 1'b1;
            if (!busy_r) begin
              sent     = 1'b1;
              busy_nxt = 1'b1;
              if (fb_ok) begin
                popped  = fb_e;
                cnt_nxt = cnt_r + CW'(1);
              end else begin
                popped   = (cnt_r == '0) ? data_e : head_ent;
                head_nxt = head_inc;
              end
            end else if (fb_ok) begin
              head_nxt   = head_dec;
              cnt_nxt    = cnt_r + CW'(2);
              pend_nxt   = 1'b1;
              pend_d_nxt = fb_e;
            end else begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end
        end
        ACT_END: begin
          if (cnt_r != '0) begin
            sent     = 1'b1;
            popped   = head_ent;
            head_nxt = head_inc;
            cnt_nxt  = cnt_r - CW'(1);
            busy_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign rd_addr = head_nxt;

  always_comb begin
    ovr_v_nxt = 1'b0;
    ovr_d_nxt = wr_data;
    if (pend_nxt) begin
      ovr_v_nxt = 1'b1;
      ovr_d_nxt = fb_e;
    end else if (wr_en && (wr_addr == rd_addr)) begin
      ovr_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      cnt_r   <= '0;
      busy_r  <= 1'b0;
      drops_r <= '0;
      pend_r  <= 1'b0;
      ovr_v_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      busy_r  <= busy_nxt;
      drops_r <= drops_nxt;
      pend_r  <= pend_nxt;
      ovr_v_r <= ovr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_d_r <= pend_d_nxt;
    ovr_d_r  <= ovr_d_nxt;
  end

  assign pend = pend_r;

  assign res = '{
    sent:           sent,
    sent_kind:      popped.kind,
    sent_handle:    popped.handle,
    sent_duration:  popped.duration,
    dropped:        dropped,
    feedback_added: fb,
    drops_so_far:   drops_nxt,
    occupancy:      OCC_W'(cnt_nxt)
  };

endmodule

// ===== rtl/tail_drop_queue_with_feedback_unit.sv =====
// Tail-drop packet queue with congestion feedback, one server.
//
// Input channel (in_valid/in_ready): one request per event, either a packet
// arrival (handle, duration) or the end of the current service.
// Result channel (out_valid/out_ready): exactly one result per request, in
// order: the entry sent to the server (if any), drop flag, feedback entry
// inserted, saturating drop count and occupancy after the request.
// Configuration: cfg_we/cfg_wdata write buffer_size; write only while idle.
//
// A request passes through the input register and the queue logic into the
// output register. Throughput: one request per cycle while the result channel
// is not stalled and no feedback write drains; a busy-server arrival that inserts
// a feedback entry makes two writes into the entry store (one write port) and holds off the next request.
// A stalled receiver holds the result in the output register; one more
// request is still taken into the input register before in_ready drops.
// Reset empties the queue, idles the server, clears the drop count and sets
// buffer_size to 200. The entry store needs no clearing pass.
module tail_drop_queue_with_feedback_unit #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_packet_handle,
  input  logic [15:0] in_packet_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sent,
  output logic [1:0]  out_sent_kind,
  output logic [31:0] out_sent_handle,
  output logic [15:0] out_sent_duration,
  output logic        out_dropped,
  output logic [1:0]  out_feedback_added,
  output logic [31:0] out_drops_so_far,
  output logic [8:0]  out_occupancy
);

  import tdq_pkg::*;

  // input register
  logic                item_v_r;
  logic                item_act_r;
  logic [HANDLE_W-1:0] item_handle_r;
  logic [DUR_W-1:0]    item_dur_r;

  // output register
  logic                out_v_r;
  res_t                res_r;

  thr_t thr;
  res_t res;
  logic pend;
  logic go;

  // advance the held request when no feedback write is draining and the
  // output register is free or being emptied
  assign go       = item_v_r && !pend && (!out_v_r || out_ready);
  assign in_ready = !item_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  // payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_act_r    <= in_action;
      item_handle_r <= in_packet_handle;
      item_dur_r    <= in_packet_duration;
    end
  end

  tdq_thresh u_thresh (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  tdq_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .act      (item_act_r),
    .handle   (item_handle_r),
    .duration (item_dur_r),
    .thr      (thr),
    .res      (res),
    .pend     (pend)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_sent           = res_r.sent;
  assign out_sent_kind      = res_r.sent_kind;
  assign out_sent_handle    = res_r.sent_handle;
  assign out_sent_duration  = res_r.sent_duration;
  assign out_dropped        = res_r.dropped;
  assign out_feedback_added = res_r.feedback_added;
  assign out_drops_so_far   = res_r.drops_so_far;
  assign out_occupancy      = res_r.occupancy;

  // the deferred feedback write drains in the following cycle
  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    pend |=> !pend)
    else $error("feedback write pending for more than one cycle");

  // every processed request shows up as a result in the next cycle
  a_go_result: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid)
    else $error("processed request produced no result");

  // a dropped packet neither starts service nor inserts feedback
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.dropped |-> !res.sent && (res.feedback_added == KIND_DATA))
    else $error("dropped packet changed the queue");

  // feedback entries carry no handle and no duration
  a_fb_empty: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.sent && (res.sent_kind != KIND_DATA)
      |-> (res.sent_handle == '0) && (res.sent_duration == '0))
    else $error("feedback entry sent with payload");

endmodule
